// ===== rtl/srtcb_pkg.sv =====
// ----------------------------------------------------------------------------
// srtcb_pkg
// Shared constants, codes and types of the serial character buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package srtcb_pkg;

  // Entries in each ring (receive and transmit).
  localparam int BUFFER_DEPTH = 1024;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);
  localparam int SUM_W        = ADDR_W + 1;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Command codes.
  localparam logic [1:0] CMD_RX    = 2'd0;
  localparam logic [1:0] CMD_TXRDY = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_WRITE = 2'd3;

  // Ring operations.
  localparam logic [1:0] RING_NONE  = 2'd0;
  localparam logic [1:0] RING_PUSH  = 2'd1;
  localparam logic [1:0] RING_POP   = 2'd2;
  localparam logic [1:0] RING_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } ring_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ring_stat_t;

endpackage

`default_nettype wire

// ===== rtl/srtcb_ram.sv =====
// ----------------------------------------------------------------------------
// srtcb_ram
// Generic single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module srtcb_ram #(
  parameter int W = 8,
  parameter int D = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] addr,
  input  wire logic [W-1:0]         wdata,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srtcb_ring.sv =====
// ----------------------------------------------------------------------------
// srtcb_ring
// Ring buffer: head/fill pointers around one RAM; push, pop, clear.
// ----------------------------------------------------------------------------
`default_nettype none

module srtcb_ring
  import srtcb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire ring_req_t  req,
  output ring_stat_t      stat,
  output logic [7:0]      rdata
);

  logic [ADDR_W-1:0] head;
  logic [FILL_W-1:0] fill;
  logic [ADDR_W-1:0] head_next;
  logic [FILL_W-1:0] fill_next;
  logic [SUM_W-1:0]  pos_sum;
  logic [SUM_W-1:0]  head_inc;
  logic [ADDR_W-1:0] wr_pos;
  logic [ADDR_W-1:0] addr;
  logic              we;
  logic              re;

  assign stat.full  = (fill == FILL_W'(BUFFER_DEPTH));
  assign stat.empty = (fill == '0);

  // tail = (head + fill) mod depth; sum stays below twice the depth
  always_comb begin
    pos_sum  = {1'b0, head} + SUM_W'(fill);
    wr_pos   = (pos_sum >= SUM_W'(BUFFER_DEPTH)) ?
               ADDR_W'(pos_sum - SUM_W'(BUFFER_DEPTH)) : ADDR_W'(pos_sum);
    head_inc = {1'b0, head} + SUM_W'(1);
  end

  assign we   = (req.op == RING_PUSH);
  assign re   = (req.op == RING_POP);
  assign addr = we ? wr_pos : head;

  always_comb begin
    head_next = head;
    fill_next = fill;
    case (req.op)
      RING_PUSH: begin
        fill_next = fill + FILL_W'(1);
      end
      RING_POP: begin
        fill_next = fill - FILL_W'(1);
        if (fill == FILL_W'(1)) begin
          head_next = '0;  // empty again: restart at entry zero
        end else if (head_inc == SUM_W'(BUFFER_DEPTH)) begin
          head_next = '0;
        end else begin
          head_next = ADDR_W'(head_inc);
        end
      end
      RING_CLEAR: begin
        head_next = '0;
        fill_next = '0;
      end
      default: begin
        head_next = head;
        fill_next = fill;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      fill <= fill_next;
    end
  end

  srtcb_ram #(
    .W (8),
    .D (BUFFER_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .re    (re),
    .addr  (addr),
    .wdata (req.data),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/serial_rx_tx_char_buffer.sv =====
// ----------------------------------------------------------------------------
// serial_rx_tx_char_buffer
// Serial character buffer controller with receive and transmit rings.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: present cmd and its operands with start high; the
//   transfer happens at the edge where start is high and busy is low.
//   Commands: received byte (CR becomes LF, goes to a waiting reader or
//   the receive ring, or is dropped when full), transmitter ready (pops
//   the next byte or ends the transmit sequence), read request (pops a
//   byte or reports none), write request (LF is sent as CR then LF; the
//   first byte goes out directly when the transmitter is idle).
//   Result channel: done is high for exactly one cycle with all result
//   ports valid; the receiver cannot stall, and a result is lost if not
//   taken in that cycle. Fields that do not concern the command read 0.
//   Sequence: a transfer enters ST_EXEC, then ST_RESP raises done; an LF
//   write while sending passes ST_PUSH2 between them (two pushes into the
//   single-port transmit RAM). busy is high in ST_EXEC and ST_PUSH2, so a
//   new command is taken only in ST_IDLE or in the cycle done is high,
//   once the registered RAM read data of the last command is shown.
//   Reset (rst, synchronous): both rings empty, transmitter idle. RAM
//   contents are not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_rx_tx_char_buffer
  import srtcb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] cmd,
  input  wire logic [7:0] rx_byte,
  input  wire logic       reader_waiting,
  input  wire logic [7:0] write_byte,
  output logic            done,
  output logic            tx_valid,
  output logic [7:0]      tx_byte,
  output logic            read_valid,
  output logic [7:0]      read_byte,
  output logic            wake_valid,
  output logic [7:0]      wake_byte,
  output logic            rx_dropped,
  output logic            tx_dropped
);

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;  // ring access issued
  localparam logic [1:0] ST_PUSH2 = 2'd2;  // second push of an LF write
  localparam logic [1:0] ST_RESP  = 2'd3;  // result shown, RAM data ready

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  // captured command
  logic [1:0] c_cmd;
  logic [7:0] c_rx;
  logic       c_wait;
  logic [7:0] c_wb;

  logic       sending;
  logic       sending_next;

  // result registers
  logic       r_tx_v;
  logic [7:0] r_tx_b;
  logic       r_from_mem;  // tx byte comes from the transmit RAM read
  logic       r_rd_v;
  logic       r_wk_v;
  logic [7:0] r_wk_b;
  logic       r_rxd;
  logic       r_txd;

  logic       n_tx_v;
  logic [7:0] n_tx_b;
  logic       n_from_mem;
  logic       n_rd_v;
  logic       n_wk_v;
  logic [7:0] n_wk_b;
  logic       n_rxd;
  logic       n_txd;

  ring_req_t  rx_req;
  ring_req_t  tx_req;
  ring_stat_t rx_stat;
  ring_stat_t tx_stat;
  logic [7:0] rx_q;
  logic [7:0] tx_q;
  logic [7:0] rx_mapped;

  assign busy   = (state == ST_EXEC) || (state == ST_PUSH2);
  assign accept = start && !busy;
  assign done   = (state == ST_RESP);

  assign rx_mapped = (c_rx == CH_CR) ? CH_LF : c_rx;

  // Command execution: one ring access per cycle, decisions from the
  // registered ring status.
  always_comb begin
    state_next   = state;
    sending_next = sending;
    rx_req       = '{op: RING_NONE, data: rx_mapped};
    tx_req       = '{op: RING_NONE, data: c_wb};
    n_tx_v       = r_tx_v;
    n_tx_b       = r_tx_b;
    n_from_mem   = r_from_mem;
    n_rd_v       = r_rd_v;
    n_wk_v       = r_wk_v;
    n_wk_b       = r_wk_b;
    n_rxd        = r_rxd;
    n_txd        = r_txd;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        n_tx_v     = 1'b0;
        n_tx_b     = '0;
        n_from_mem = 1'b0;
        n_rd_v     = 1'b0;
        n_wk_v     = 1'b0;
        n_wk_b     = '0;
        n_rxd      = 1'b0;
        n_txd      = 1'b0;
        state_next = ST_RESP;
        case (c_cmd)
          CMD_RX: begin
            if (c_wait) begin
              n_wk_v = 1'b1;
              n_wk_b = rx_mapped;
            end else if (!rx_stat.full) begin
              rx_req.op = RING_PUSH;
            end else begin
              n_rxd = 1'b1;
            end
          end
          CMD_TXRDY: begin
            if (sending && !tx_stat.empty) begin
              tx_req.op  = RING_POP;
              n_tx_v     = 1'b1;
              n_from_mem = 1'b1;
            end else begin
              tx_req.op    = RING_CLEAR;
              sending_next = 1'b0;
            end
          end
          CMD_READ: begin
            if (!rx_stat.empty) begin
              rx_req.op = RING_POP;
              n_rd_v    = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (!sending) begin
              // first byte goes straight out; idle implies empty ring
              sending_next = 1'b1;
              n_tx_v       = 1'b1;
              if (c_wb == CH_LF) begin
                n_tx_b    = CH_CR;
                tx_req.op = RING_PUSH;
              end else begin
                n_tx_b = c_wb;
              end
            end else begin
              if (c_wb == CH_LF) begin
                tx_req.data = CH_CR;
                state_next  = ST_PUSH2;
              end
              if (!tx_stat.full) begin
                tx_req.op = RING_PUSH;
              end else begin
                n_txd = 1'b1;
              end
            end
          end
          default: begin
            state_next = ST_RESP;
          end
        endcase
      end
      ST_PUSH2: begin
        // LF after the queued CR
        state_next = ST_RESP;
        if (!tx_stat.full) begin
          tx_req.op = RING_PUSH;
        end else begin
          n_txd = 1'b1;
        end
      end
      ST_RESP: begin
        state_next = accept ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      sending <= 1'b0;
    end else begin
      state   <= state_next;
      sending <= sending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      c_cmd  <= cmd;
      c_rx   <= rx_byte;
      c_wait <= reader_waiting;
      c_wb   <= write_byte;
    end
    r_tx_v     <= n_tx_v;
    r_tx_b     <= n_tx_b;
    r_from_mem <= n_from_mem;
    r_rd_v     <= n_rd_v;
    r_wk_v     <= n_wk_v;
    r_wk_b     <= n_wk_b;
    r_rxd      <= n_rxd;
    r_txd      <= n_txd;
  end

  srtcb_ring u_rx_ring (
    .clk   (clk),
    .rst   (rst),
    .req   (rx_req),
    .stat  (rx_stat),
    .rdata (rx_q)
  );

  srtcb_ring u_tx_ring (
    .clk   (clk),
    .rst   (rst),
    .req   (tx_req),
    .stat  (tx_stat),
    .rdata (tx_q)
  );

  // Result ports; popped bytes come straight from the RAM output register.
  assign tx_valid   = r_tx_v;
  assign tx_byte    = r_tx_v ? (r_from_mem ? tx_q : r_tx_b) : 8'h00;
  assign read_valid = r_rd_v;
  assign read_byte  = r_rd_v ? rx_q : 8'h00;
  assign wake_valid = r_wk_v;
  assign wake_byte  = r_wk_b;
  assign rx_dropped = r_rxd;
  assign tx_dropped = r_txd;

endmodule

`default_nettype wire

// ===== rtl/srtcb_chk.sv =====
// ----------------------------------------------------------------------------
// srtcb_chk
// Port-level checks of the serial character buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module srtcb_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic       tx_valid,
  input wire logic [7:0] tx_byte,
  input wire logic       read_valid,
  input wire logic [7:0] read_byte,
  input wire logic       wake_valid,
  input wire logic [7:0] wake_byte,
  input wire logic       rx_dropped,
  input wire logic       tx_dropped
);

  // a transfer always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("transfer did not start work");

  // one result per command, never back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held two cycles");

  // a result concerns one kind of command only
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot0({read_valid, wake_valid, rx_dropped, tx_valid || tx_dropped}))
    else $error("result mixes command kinds");

  // bytes without their valid read as zero
  a_zero_bytes: assert property (@(posedge clk) disable iff (rst)
    done |-> (tx_valid || tx_byte == 8'h00) && (read_valid || read_byte == 8'h00) &&
             (wake_valid || wake_byte == 8'h00))
    else $error("byte set without its valid");

endmodule

bind serial_rx_tx_char_buffer srtcb_chk u_srtcb_chk (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .tx_valid   (tx_valid),
  .tx_byte    (tx_byte),
  .read_valid (read_valid),
  .read_byte  (read_byte),
  .wake_valid (wake_valid),
  .wake_byte  (wake_byte),
  .rx_dropped (rx_dropped),
  .tx_dropped (tx_dropped)
);

`default_nettype wire
